// File: rtl/gdad_pkg.sv
package gdad_pkg;

    // Input and result field widths
    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int DAYS_W  = 16;
    localparam int STAT_W  = 2;

    // Day counts beyond this width are ignored
    localparam int DAYS_WIDTH = 16;
    localparam int REM_W      = (DAYS_WIDTH < DAYS_W) ? DAYS_WIDTH : DAYS_W;

    localparam logic [YEAR_W-1:0]  MAX_YEAR = YEAR_W'(9999);
    localparam logic [MONTH_W-1:0] DECEMBER = MONTH_W'(12);
    localparam logic [MONTH_W-1:0] JANUARY  = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] FEBRUARY = MONTH_W'(2);

    // year / 100 == (year * CENT_RECIP) >> CENT_SHIFT for every 14-bit year
    localparam int CENT_RECIP_W = 13;
    localparam logic [CENT_RECIP_W-1:0] CENT_RECIP = CENT_RECIP_W'(5243);
    localparam int PROD_W     = YEAR_W + CENT_RECIP_W;
    localparam int CENT_SHIFT = 19;
    localparam int CENT_W     = PROD_W - CENT_SHIFT;
    localparam int YREM_W     = 7;
    localparam logic [YREM_W-1:0] YREM_LAST = YREM_W'(99);

    localparam logic [STAT_W-1:0] STATUS_OK        = STAT_W'(0);
    localparam logic [STAT_W-1:0] STATUS_BAD_START = STAT_W'(1);
    localparam logic [STAT_W-1:0] STATUS_OVERFLOW  = STAT_W'(2);

    typedef struct packed {
        logic load;
        logic mult;
        logic split;
        logic check;
        logic step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic finish;
    } t_sts;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        if (month inside {4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12}) begin
            len = DAY_W'(31);
        end else if (month == FEBRUARY) begin
            len = leap ? DAY_W'(29) : DAY_W'(28);
        end else begin
            len = DAY_W'(30);
        end
        return len;
    endfunction

endpackage

// File: rtl/gdad_ctrl.sv
module gdad_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    input  gdad_pkg::t_sts  i_sts,
    output gdad_pkg::t_cmd  o_cmd
);
    import gdad_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MULT,
        S_SPLIT,
        S_CHECK,
        S_STEP,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MULT;
                end
            end
            S_MULT: begin
                o_cmd.mult = 1'b1;
                n_state    = S_SPLIT;
            end
            S_SPLIT: begin
                o_cmd.split = 1'b1;
                n_state     = S_CHECK;
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = S_STEP;
            end
            S_STEP: begin
                if (i_sts.finish) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_DONE: begin
                // hold the result until the output register frees up
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// File: rtl/gdad_dpath.sv
module gdad_dpath (
    input  logic                            i_clk,
    input  gdad_pkg::t_cmd                  i_cmd,
    output gdad_pkg::t_sts                  o_sts,
    input  logic [gdad_pkg::DAY_W-1:0]      i_start_day,
    input  logic [gdad_pkg::MONTH_W-1:0]    i_start_month,
    input  logic [gdad_pkg::YEAR_W-1:0]     i_start_year,
    input  logic [gdad_pkg::DAYS_W-1:0]     i_days_to_add,
    output logic [gdad_pkg::DAY_W-1:0]      o_result_day,
    output logic [gdad_pkg::MONTH_W-1:0]    o_result_month,
    output logic [gdad_pkg::YEAR_W-1:0]     o_result_year,
    output logic [gdad_pkg::STAT_W-1:0]     o_status
);
    import gdad_pkg::*;

    logic [DAY_W-1:0]   r_day;
    logic [MONTH_W-1:0] r_month;
    logic [YEAR_W-1:0]  r_year;
    logic [REM_W-1:0]   r_rem;
    logic [STAT_W-1:0]  r_status;
    logic [PROD_W-1:0]  r_prod;
    logic [CENT_W-1:0]  r_cent;
    logic [YREM_W-1:0]  r_yrem;

    logic [DAY_W-1:0]   r_out_day;
    logic [MONTH_W-1:0] r_out_month;
    logic [YEAR_W-1:0]  r_out_year;
    logic [STAT_W-1:0]  r_out_status;

    logic [CENT_W-1:0]  cent;
    logic [YEAR_W-1:0]  cent_x100;
    logic               leap;
    logic [DAY_W-1:0]   len;
    logic [DAY_W-1:0]   to_end;
    logic               bad_start;
    logic               fits;

    assign cent      = r_prod[PROD_W-1:CENT_SHIFT];
    assign cent_x100 = YEAR_W'({cent, 6'b0}) + YEAR_W'({cent, 5'b0}) + YEAR_W'({cent, 2'b0});

    // divisible by 4, and not a century unless the century count is a multiple of 4
    assign leap   = (r_year[1:0] == 2'd0) && ((r_yrem != '0) || (r_cent[1:0] == 2'd0));
    assign len    = month_len(r_month, leap);
    assign to_end = len - r_day;
    assign fits   = (r_rem <= REM_W'(to_end));

    assign bad_start = (r_month == '0) || (r_month > DECEMBER) || (r_year > MAX_YEAR) ||
                       (r_day == '0) || (r_day > len);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_day    <= i_start_day;
            r_month  <= i_start_month;
            r_year   <= i_start_year;
            r_rem    <= i_days_to_add[REM_W-1:0];
            r_status <= STATUS_OK;
        end
        if (i_cmd.mult) begin
            r_prod <= PROD_W'(r_year) * PROD_W'(CENT_RECIP);
        end
        if (i_cmd.split) begin
            r_cent <= cent;
            r_yrem <= YREM_W'(r_year - cent_x100);
        end
        if (i_cmd.check && bad_start) begin
            r_status <= STATUS_BAD_START;
            r_rem    <= '0;
        end
        if (i_cmd.step) begin
            if (fits) begin
                r_day <= r_day + DAY_W'(r_rem);
                r_rem <= '0;
            end else if ((r_month == DECEMBER) && (r_year == MAX_YEAR)) begin
                r_day    <= DAY_W'(31);
                r_status <= STATUS_OVERFLOW;
                r_rem    <= '0;
            end else begin
                r_rem <= r_rem - REM_W'(to_end) - REM_W'(1);
                r_day <= DAY_W'(1);
                if (r_month == DECEMBER) begin
                    r_month <= JANUARY;
                    r_year  <= r_year + YEAR_W'(1);
                    if (r_yrem == YREM_LAST) begin
                        r_yrem <= '0;
                        r_cent <= r_cent + CENT_W'(1);
                    end else begin
                        r_yrem <= r_yrem + YREM_W'(1);
                    end
                end else begin
                    r_month <= r_month + MONTH_W'(1);
                end
            end
        end
        if (i_cmd.out_load) begin
            r_out_day    <= r_day;
            r_out_month  <= r_month;
            r_out_year   <= r_year;
            r_out_status <= r_status;
        end
    end

    assign o_sts.finish   = (r_rem == '0);
    assign o_result_day   = r_out_day;
    assign o_result_month = r_out_month;
    assign o_result_year  = r_out_year;
    assign o_status       = r_out_status;

endmodule

// File: rtl/gregorian_date_add_days.sv
// Chan | Dir | Valid / stall            | Payload
// in   | in  | i_in_valid / o_in_stall  | i_start_day, i_start_month, i_start_year, i_days_to_add
// out  | out | o_out_valid / i_out_stall | o_result_day, o_result_month, o_result_year, o_status
//
// One transaction at a time. Setup runs capture, century multiply, century split
// and validity check in turn. The month walker then steps once per month boundary
// crossed and once more on a last partial month, then finishes and loads the output
// register once it is free. The month walk dominates the time a transaction takes.
// Reset (i_rst_n, synchronous, active low) clears the state machine and the output valid.
// The output register holds a finished result while i_out_stall is high; the next
// result waits in the datapath until it is taken.
module gregorian_date_add_days (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [gdad_pkg::DAY_W-1:0]      i_start_day,
    input  logic [gdad_pkg::MONTH_W-1:0]    i_start_month,
    input  logic [gdad_pkg::YEAR_W-1:0]     i_start_year,
    input  logic [gdad_pkg::DAYS_W-1:0]     i_days_to_add,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [gdad_pkg::DAY_W-1:0]      o_result_day,
    output logic [gdad_pkg::MONTH_W-1:0]    o_result_month,
    output logic [gdad_pkg::YEAR_W-1:0]     o_result_year,
    output logic [gdad_pkg::STAT_W-1:0]     o_status
);
    import gdad_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Sequence setup, month walk and output handoff
    gdad_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Date registers, leap tracking and the output register
    gdad_dpath u_dpath (
        .i_clk          (i_clk),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_start_day    (i_start_day),
        .i_start_month  (i_start_month),
        .i_start_year   (i_start_year),
        .i_days_to_add  (i_days_to_add),
        .o_result_day   (o_result_day),
        .o_result_month (o_result_month),
        .o_result_year  (o_result_year),
        .o_status       (o_status)
    );

`ifndef SYNTHESIS
    // An accepted transaction keeps the input side closed for the setup cycles
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted again right after a transaction");

    // Overflow always pins the date at the last day of the last year
    a_overflow_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == STATUS_OVERFLOW)) |->
        ((o_result_day == DAY_W'(31)) && (o_result_month == DECEMBER) &&
         (o_result_year == MAX_YEAR)))
        else $error("overflow result is not December 31 of the last year");

    // A good result is a well formed date
    a_ok_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == STATUS_OK)) |->
        ((o_result_day != '0) && (o_result_month != '0) && (o_result_month <= DECEMBER) &&
         (o_result_year <= MAX_YEAR)))
        else $error("ok result holds a malformed date");
`endif

endmodule
